/* src/smfr_pkg.sv */
package smfr_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] REG_CR1    = 3'd0;
  localparam logic [2:0] REG_CR2    = 3'd1;
  localparam logic [2:0] REG_SR     = 3'd2;
  localparam logic [2:0] REG_DR     = 3'd3;
  localparam logic [2:0] REG_CSCTRL = 3'd4;

  localparam int CR1_MSTR_BIT  = 2;
  localparam int CR1_SPE_BIT   = 6;
  localparam int CR2_SSOE_BIT  = 2;
  localparam int CR2_ERRIE_BIT = 5;
  localparam int CR2_RXNE_BIT  = 6;
  localparam int CR2_TXE_BIT   = 7;
  localparam int SR_RXNE_BIT   = 0;
  localparam int SR_TXE_BIT    = 1;
  localparam int SR_UDR_BIT    = 2;
  localparam int SR_OVR_BIT    = 3;

  typedef struct packed {
    logic        action;
    logic [2:0]  reg_index;
    logic [31:0] write_data;
    logic [7:0]  miso_byte;
  } in_word_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        spi_tx_valid;
    logic [7:0]  spi_tx_byte;
    logic        irq_level;
    logic        access_error;
  } out_word_t;

  typedef struct packed {
    logic clear;
    logic push;
    logic pop;
  } fifo_ctrl_t;

endpackage

/* src/smfr_fifo.sv */
module smfr_fifo (
  input  logic                     clk,
  input  logic                     rst_n,
  input  smfr_pkg::fifo_ctrl_t     ctl,
  input  logic [7:0]               push_data,
  output logic [7:0]               pop_data,
  output logic                     empty,
  output logic                     full,
  output logic [smfr_pkg::CNT_W-1:0] count_nxt
);

  logic [7:0]                 mem_r [smfr_pkg::QUEUE_DEPTH];
  logic [smfr_pkg::PTR_W-1:0] head_r, head_nxt;
  logic [smfr_pkg::PTR_W-1:0] tail_r, tail_nxt;
  logic [smfr_pkg::CNT_W-1:0] count_r;

  function automatic logic [smfr_pkg::PTR_W-1:0] bump(input logic [smfr_pkg::PTR_W-1:0] p);
    logic [smfr_pkg::PTR_W-1:0] last;
    last = smfr_pkg::PTR_W'(smfr_pkg::QUEUE_DEPTH - 1);
    return (p == last) ? '0 : p + smfr_pkg::PTR_W'(1);
  endfunction

  assign empty = (count_r == '0);
  assign full  = (count_r == smfr_pkg::CNT_W'(smfr_pkg::QUEUE_DEPTH));
  // an empty queue hands the incoming byte straight through
  assign pop_data = empty ? push_data : mem_r[head_r];

  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (ctl.clear) begin
      head_nxt  = '0;
      tail_nxt  = '0;
      count_nxt = '0;
    end else begin
      if (ctl.push) begin
        tail_nxt = bump(tail_r);
      end
      if (ctl.pop) begin
        head_nxt = bump(head_r);
      end
      count_nxt = count_r + smfr_pkg::CNT_W'(ctl.push) - smfr_pkg::CNT_W'(ctl.pop);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push && !ctl.clear) begin
      mem_r[tail_r] <= push_data;
    end
  end

endmodule

/* src/smfr_core.sv */
module smfr_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 fire,
  input  smfr_pkg::in_word_t   word,
  output smfr_pkg::out_word_t  result
);

  logic [1:0] ctrl_one_r, ctrl_one_nxt;
  logic [3:0] ctrl_two_r, ctrl_two_nxt;
  logic [1:0] err_flags_r, err_flags_nxt;
  logic [7:0] csc_r, csc_nxt;

  smfr_pkg::fifo_ctrl_t tx_ctl, rx_ctl;
  logic [7:0] tx_pop_data, rx_pop_data;
  logic       tx_empty, tx_full, rx_empty, rx_full;
  logic [smfr_pkg::CNT_W-1:0] tx_count_nxt, rx_count_nxt;

  logic       gate_open, dr_act, tx_push, rx_pop, xfer, ovr_set, sr_wr;
  logic       cs_bad, bad_index;
  logic [1:0] new_flags;
  logic [3:0] cs_bits;
  logic       rxne, txe;

  smfr_fifo u_tx_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (tx_ctl),
    .push_data (word.write_data[7:0]),
    .pop_data  (tx_pop_data),
    .empty     (tx_empty),
    .full      (tx_full),
    .count_nxt (tx_count_nxt)
  );

  smfr_fifo u_rx_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (rx_ctl),
    .push_data (word.miso_byte),
    .pop_data  (rx_pop_data),
    .empty     (rx_empty),
    .full      (rx_full),
    .count_nxt (rx_count_nxt)
  );

  always_comb begin
    gate_open = ctrl_one_r[1] & (|(csc_r[7:4] & csc_r[3:0]));
    dr_act    = (word.reg_index == smfr_pkg::REG_DR) & gate_open;
    tx_push   = dr_act & word.action & !tx_full;
    ovr_set   = dr_act & word.action & tx_full;
    rx_pop    = dr_act & !word.action & !rx_empty;
    xfer      = dr_act & (tx_push | !tx_empty) & (rx_pop | !rx_full);
    sr_wr     = word.action & (word.reg_index == smfr_pkg::REG_SR);
    new_flags = {word.write_data[smfr_pkg::SR_OVR_BIT], word.write_data[smfr_pkg::SR_UDR_BIT]};
    cs_bits   = word.write_data[7:4];
    cs_bad    = (|word.write_data[31:8]) | (|(cs_bits & (cs_bits - 4'd1)));
    bad_index = (word.reg_index > smfr_pkg::REG_CSCTRL);

    tx_ctl.clear = fire & sr_wr & err_flags_r[1] & !new_flags[1];
    tx_ctl.push  = fire & tx_push;
    tx_ctl.pop   = fire & xfer;
    rx_ctl.clear = fire & sr_wr & err_flags_r[0] & !new_flags[0];
    rx_ctl.push  = fire & xfer;
    rx_ctl.pop   = fire & rx_pop;

    ctrl_one_nxt  = ctrl_one_r;
    ctrl_two_nxt  = ctrl_two_r;
    err_flags_nxt = err_flags_r;
    csc_nxt       = csc_r;
    if (fire && word.action) begin
      case (word.reg_index)
        smfr_pkg::REG_CR1: begin
          ctrl_one_nxt = {word.write_data[smfr_pkg::CR1_SPE_BIT],
                          word.write_data[smfr_pkg::CR1_MSTR_BIT]};
        end
        smfr_pkg::REG_CR2: begin
          ctrl_two_nxt = {word.write_data[smfr_pkg::CR2_TXE_BIT],
                          word.write_data[smfr_pkg::CR2_RXNE_BIT],
                          word.write_data[smfr_pkg::CR2_ERRIE_BIT],
                          word.write_data[smfr_pkg::CR2_SSOE_BIT]};
        end
        smfr_pkg::REG_SR: begin
          err_flags_nxt = new_flags;
        end
        smfr_pkg::REG_DR: begin
          if (ovr_set) begin
            err_flags_nxt = err_flags_r | 2'b10;
          end
        end
        smfr_pkg::REG_CSCTRL: begin
          if (!cs_bad) begin
            csc_nxt = word.write_data[7:0];
          end
        end
        default: begin
        end
      endcase
    end

    result.read_data = '0;
    if (!word.action) begin
      case (word.reg_index)
        smfr_pkg::REG_CR1: begin
          result.read_data[smfr_pkg::CR1_MSTR_BIT] = ctrl_one_r[0];
          result.read_data[smfr_pkg::CR1_SPE_BIT]  = ctrl_one_r[1];
        end
        smfr_pkg::REG_CR2: begin
          result.read_data[smfr_pkg::CR2_SSOE_BIT]  = ctrl_two_r[0];
          result.read_data[smfr_pkg::CR2_ERRIE_BIT] = ctrl_two_r[1];
          result.read_data[smfr_pkg::CR2_RXNE_BIT]  = ctrl_two_r[2];
          result.read_data[smfr_pkg::CR2_TXE_BIT]   = ctrl_two_r[3];
        end
        smfr_pkg::REG_SR: begin
          result.read_data[smfr_pkg::SR_RXNE_BIT] = !rx_empty;
          result.read_data[smfr_pkg::SR_TXE_BIT]  = !tx_full;
          result.read_data[smfr_pkg::SR_UDR_BIT]  = err_flags_r[0];
          result.read_data[smfr_pkg::SR_OVR_BIT]  = err_flags_r[1];
        end
        smfr_pkg::REG_DR: begin
          if (rx_pop) begin
            result.read_data[7:0] = rx_pop_data;
          end
        end
        smfr_pkg::REG_CSCTRL: begin
          result.read_data[7:0] = csc_r;
        end
        default: begin
        end
      endcase
    end

    result.spi_tx_valid = xfer;
    result.spi_tx_byte  = xfer ? tx_pop_data : 8'd0;
    result.access_error = bad_index |
                          (word.action & (word.reg_index == smfr_pkg::REG_CSCTRL) & cs_bad);

    // interrupt looks at the state left behind by this access
    rxne = (rx_count_nxt != '0);
    txe  = (tx_count_nxt != smfr_pkg::CNT_W'(smfr_pkg::QUEUE_DEPTH));
    result.irq_level = ctrl_two_nxt[0] &
                       ((rxne & ctrl_two_nxt[2]) | (txe & ctrl_two_nxt[3]) |
                        ((|err_flags_nxt) & ctrl_two_nxt[1]));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctrl_one_r  <= '0;
      ctrl_two_r  <= '0;
      err_flags_r <= '0;
      csc_r       <= '0;
    end else begin
      ctrl_one_r  <= ctrl_one_nxt;
      ctrl_two_r  <= ctrl_two_nxt;
      err_flags_r <= err_flags_nxt;
      csc_r       <= csc_nxt;
    end
  end

endmodule

/* src/spi_master_fifo_registers.sv */
// SPI master register block with 16-byte transmit and receive queues. Each input word is one
// register access (CR1, CR2, SR, DR, CSCTRL at word indices 0 to 4) and gives exactly one output
// word: read data, the byte exchanged on the bus if any, the interrupt level after the access and
// an access error flag. A word is captured in an input register, decoded and applied to the
// register and queue state once the output register can take its result, and its result is
// held in an output register; one word per cycle is sustained while the output is not stalled.
// Both queues reset empty; queue storage itself is not cleared.
module spi_master_fifo_registers (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  smfr_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output smfr_pkg::out_word_t out_word
);

  logic                s1_valid_r, s1_valid_nxt;
  smfr_pkg::in_word_t  s1_word_r;
  logic                out_valid_r, out_valid_nxt;
  smfr_pkg::out_word_t out_word_r;
  smfr_pkg::out_word_t result;
  logic                fire;
  logic                in_take;

  assign fire     = s1_valid_r & (!out_valid_r | !out_stall);
  assign in_stall = s1_valid_r & !fire;
  assign in_take  = in_valid & !in_stall;

  assign s1_valid_nxt  = in_take | (s1_valid_r & !fire);
  assign out_valid_nxt = fire | (out_valid_r & out_stall);

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  smfr_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .word   (s1_word_r),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_word_r <= in_word;
    end
    if (fire) begin
      out_word_r <= result;
    end
  end

  a_stall_needs_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with empty input register");

  a_fire_loads_out: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> out_valid_r)
    else $error("processed word did not reach output register");

  a_idle_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_word_r.spi_tx_valid) |-> (out_word_r.spi_tx_byte == 8'd0))
    else $error("tx byte set without a transfer");

  a_error_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.access_error) |-> (out_word_r.read_data == 32'd0))
    else $error("read data returned on a failed access");

endmodule
